FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL of the front/middle/back queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FMBQ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define FMBQ_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define FMBQ_ASSERT(lbl, clk, rstn, prop, msg)
`define FMBQ_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: rtl/fmbq_pkg.sv
// Package of types and constants for the front/middle/back queue.
package fmbq_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int WORD_W = 32;
	localparam int CNT_W = 11;
	localparam int OP_W = 3;
	localparam int GROUP = 32;
	localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_MIDDLE = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_BACK = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_POP_MIDDLE = 3'd4;
	localparam logic [OP_W-1:0] OP_POP_BACK = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FINISH
	} fmbq_state_t;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic ins;
		logic rem;
		logic [IDX_W-1:0] pos;
		logic signed [WORD_W-1:0] val;
	} cell_ctrl_t;

endpackage

FILE: rtl/fmbq_cell.sv
// One storage cell of the queue row, with shift-left, shift-right and load.
module fmbq_cell (
	input logic clk,
	input logic [fmbq_pkg::IDX_W-1:0] idx,
	input fmbq_pkg::cell_ctrl_t ctrl,
	input logic signed [fmbq_pkg::WORD_W-1:0] left_word,
	input logic signed [fmbq_pkg::WORD_W-1:0] right_word,
	output logic signed [fmbq_pkg::WORD_W-1:0] word,
	output logic signed [fmbq_pkg::WORD_W-1:0] tap
);

	logic signed [fmbq_pkg::WORD_W-1:0] data_q;
	logic at_pos;
	logic past_pos;

	assign at_pos = (idx == ctrl.pos);
	assign past_pos = (idx > ctrl.pos);

	// An insert opens a gap at the position; a removal closes it from behind.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (at_pos) begin
				data_q <= ctrl.val;
			end else if (past_pos) begin
				data_q <= left_word;
			end
		end else if (ctrl.rem && (at_pos || past_pos)) begin
			data_q <= right_word;
		end
	end

	assign word = data_q;
	assign tap = at_pos ? data_q : '0;

endmodule

FILE: rtl/fmbq_collect.sv
// Two-level OR tree, first level registered, that picks the selected cell's word out of the row.
module fmbq_collect (
	input logic clk,
	input logic en,
	input logic signed [fmbq_pkg::WORD_W-1:0] taps [fmbq_pkg::CAPACITY],
	output logic signed [fmbq_pkg::WORD_W-1:0] word
);

	logic [fmbq_pkg::WORD_W-1:0] group_s1 [fmbq_pkg::NGROUP];

	for (genvar g = 0; g < fmbq_pkg::NGROUP; g++) begin : g_grp
		logic [fmbq_pkg::WORD_W-1:0] acc;

		always_comb begin
			acc = '0;
			for (int k = 0; k < fmbq_pkg::GROUP; k++) begin
				if (g * fmbq_pkg::GROUP + k < fmbq_pkg::CAPACITY) begin
					acc = acc | taps[g * fmbq_pkg::GROUP + k];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				group_s1[g] <= acc;
			end
		end
	end

	always_comb begin
		word = '0;
		for (int g = 0; g < fmbq_pkg::NGROUP; g++) begin
			word = word | group_s1[g];
		end
	end

endmodule

FILE: rtl/front_middle_back_queue_top.sv
// An accepted transaction passes through the execute and finish states before its result
// is valid; a new one is taken only back in idle. Steps: accept; execute, where the cell
// row shifts and the read tree captures; finish, for the second tree level and the output
// register. A stalled output holds the block in its final step.
// Reset clears occupancy, control and the output valid; cell words are not reset.
`include "assert_macros.svh"

module front_middle_back_queue_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [fmbq_pkg::OP_W-1:0] operation,
	input logic signed [fmbq_pkg::WORD_W-1:0] push_value,
	output logic out_valid,
	input logic out_ready,
	output logic signed [fmbq_pkg::WORD_W-1:0] popped_value,
	output logic was_empty,
	output logic was_full,
	output logic [fmbq_pkg::CNT_W-1:0] entry_count
);

	fmbq_pkg::fmbq_state_t state_q;
	fmbq_pkg::fmbq_state_t state_d;

	logic [fmbq_pkg::OCC_W-1:0] occ_q;
	fmbq_pkg::cell_ctrl_t ctrl_q;
	fmbq_pkg::cell_ctrl_t ctrl_d;
	fmbq_pkg::cell_ctrl_t cell_ctrl;
	logic pop_q;
	logic empty_q;
	logic full_q;
	logic pop_d;
	logic empty_d;
	logic full_d;
	logic is_full;
	logic is_empty;
	logic accept;
	logic exec;
	logic load_out;
	logic out_valid_q;
	logic [fmbq_pkg::OCC_W-1:0] occ_dec;

	logic signed [fmbq_pkg::WORD_W-1:0] cell_word [fmbq_pkg::CAPACITY];
	logic signed [fmbq_pkg::WORD_W-1:0] cell_tap [fmbq_pkg::CAPACITY];
	logic signed [fmbq_pkg::WORD_W-1:0] picked_word;

	assign is_full = (occ_q == fmbq_pkg::OCC_W'(fmbq_pkg::CAPACITY));
	assign is_empty = (occ_q == '0);
	assign occ_dec = occ_q - fmbq_pkg::OCC_W'(1);
	assign accept = in_valid && in_ready;
	assign exec = (state_q == fmbq_pkg::ST_EXEC);

	// Decode the operation into an insert or a removal position, or neither for a spare code, a full push or an empty pop.
	always_comb begin
		ctrl_d.ins = 1'b0;
		ctrl_d.rem = 1'b0;
		ctrl_d.pos = '0;
		ctrl_d.val = push_value;
		pop_d = 1'b0;
		empty_d = 1'b0;
		full_d = 1'b0;
		case (operation)
			fmbq_pkg::OP_PUSH_FRONT: begin
				ctrl_d.ins = !is_full;
				full_d = is_full;
			end
			fmbq_pkg::OP_PUSH_MIDDLE: begin
				ctrl_d.ins = !is_full;
				full_d = is_full;
				ctrl_d.pos = fmbq_pkg::IDX_W'(occ_q >> 1);
			end
			fmbq_pkg::OP_PUSH_BACK: begin
				ctrl_d.ins = !is_full;
				full_d = is_full;
				ctrl_d.pos = fmbq_pkg::IDX_W'(occ_q);
			end
			fmbq_pkg::OP_POP_FRONT: begin
				ctrl_d.rem = !is_empty;
				pop_d = !is_empty;
				empty_d = is_empty;
			end
			fmbq_pkg::OP_POP_MIDDLE: begin
				ctrl_d.rem = !is_empty;
				pop_d = !is_empty;
				empty_d = is_empty;
				ctrl_d.pos = fmbq_pkg::IDX_W'(occ_dec >> 1);
			end
			fmbq_pkg::OP_POP_BACK: begin
				ctrl_d.rem = !is_empty;
				pop_d = !is_empty;
				empty_d = is_empty;
				ctrl_d.pos = fmbq_pkg::IDX_W'(occ_dec);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmbq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			fmbq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = fmbq_pkg::ST_EXEC;
				end
			end
			fmbq_pkg::ST_EXEC: begin
				state_d = fmbq_pkg::ST_FINISH;
			end
			fmbq_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = fmbq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fmbq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.ins <= 1'b0;
			ctrl_q.rem <= 1'b0;
			ctrl_q.pos <= '0;
			ctrl_q.val <= '0;
			pop_q <= 1'b0;
			empty_q <= 1'b0;
			full_q <= 1'b0;
		end else if (accept) begin
			ctrl_q.ins <= ctrl_d.ins;
			ctrl_q.rem <= ctrl_d.rem;
			ctrl_q.pos <= ctrl_d.pos;
			ctrl_q.val <= ctrl_d.val;
			pop_q <= pop_d;
			empty_q <= empty_d;
			full_q <= full_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (exec) begin
			if (ctrl_q.ins) begin
				occ_q <= occ_q + fmbq_pkg::OCC_W'(1);
			end else if (ctrl_q.rem) begin
				occ_q <= occ_dec;
			end
		end
	end

	// The row only moves during the execute cycle.
	always_comb begin
		cell_ctrl = ctrl_q;
		cell_ctrl.ins = ctrl_q.ins && exec;
		cell_ctrl.rem = ctrl_q.rem && exec;
	end

	for (genvar i = 0; i < fmbq_pkg::CAPACITY; i++) begin : g_cell
		logic signed [fmbq_pkg::WORD_W-1:0] left_w;
		logic signed [fmbq_pkg::WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == fmbq_pkg::CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end

		fmbq_cell u_cell (
			.clk(clk),
			.idx(fmbq_pkg::IDX_W'(i)),
			.ctrl(cell_ctrl),
			.left_word(left_w),
			.right_word(right_w),
			.word(cell_word[i]),
			.tap(cell_tap[i])
		);
	end

	// The first tree level samples the row before it shifts.
	fmbq_collect u_collect (
		.clk(clk),
		.en(exec),
		.taps(cell_tap),
		.word(picked_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (pop_q) begin
				popped_value <= picked_word;
			end else if (empty_q) begin
				popped_value <= '1;
			end else begin
				popped_value <= '0;
			end
			was_empty <= empty_q;
			was_full <= full_q;
			entry_count <= fmbq_pkg::CNT_W'(occ_q);
		end
	end

	assign out_valid = out_valid_q;

	`FMBQ_NEVER(a_occ_bound, clk, arst_n, occ_q > fmbq_pkg::OCC_W'(fmbq_pkg::CAPACITY), "occupancy above capacity")
	`FMBQ_ASSERT(a_occ_only_exec, clk, arst_n, !$stable(occ_q) |-> $past(state_q == fmbq_pkg::ST_EXEC), "occupancy changed outside execute")
	`FMBQ_ASSERT(a_accept_exec, clk, arst_n, accept |=> (state_q == fmbq_pkg::ST_EXEC), "accepted transaction not executed")
	`FMBQ_ASSERT(a_out_from_finish, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == fmbq_pkg::ST_FINISH), "result loaded outside finish")
	`FMBQ_NEVER(a_ins_and_rem, clk, arst_n, ctrl_q.ins && ctrl_q.rem, "insert and removal together")

endmodule

FILE: verif/tb_front_middle_back_queue_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the front/middle/back queue: a directed table, then random traffic.
module tb_front_middle_back_queue_top;

	localparam logic [fmbq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [fmbq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_AFTER = 100;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic signed [fmbq_pkg::WORD_W-1:0] popped;
		logic empty;
		logic full;
		logic [fmbq_pkg::CNT_W-1:0] count;
	} qresult_t;

	typedef struct {
		logic [fmbq_pkg::OP_W-1:0] op;
		logic signed [fmbq_pkg::WORD_W-1:0] val;
		bit typed;
		qresult_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [fmbq_pkg::OP_W-1:0] operation;
	logic signed [fmbq_pkg::WORD_W-1:0] push_value;
	logic out_valid;
	logic out_ready;
	logic signed [fmbq_pkg::WORD_W-1:0] popped_value;
	logic was_empty;
	logic was_full;
	logic [fmbq_pkg::CNT_W-1:0] entry_count;

	logic signed [fmbq_pkg::WORD_W-1:0] shadow_words[$];
	qresult_t awaited_results[$];
	script_row_t script[$];
	int results_seen = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_quiet = 0;

	front_middle_back_queue_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.popped_value(popped_value),
		.was_empty(was_empty),
		.was_full(was_full),
		.entry_count(entry_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Applies one operation to the shadow copy of the queue and returns its result.
	function automatic qresult_t queue_step(input logic [fmbq_pkg::OP_W-1:0] op,
			input logic signed [fmbq_pkg::WORD_W-1:0] val);
		qresult_t r;
		int depth;
		int idx;
		r = '0;
		depth = shadow_words.size();
		if (op == fmbq_pkg::OP_PUSH_FRONT || op == fmbq_pkg::OP_PUSH_MIDDLE
				|| op == fmbq_pkg::OP_PUSH_BACK) begin
			if (depth >= fmbq_pkg::CAPACITY)
				r.full = 1'b1;
			else if (op == fmbq_pkg::OP_PUSH_FRONT)
				shadow_words.push_front(val);
			else if (op == fmbq_pkg::OP_PUSH_MIDDLE)
				shadow_words.insert(depth / 2, val);
			else
				shadow_words.push_back(val);
		end else if (op == fmbq_pkg::OP_POP_FRONT || op == fmbq_pkg::OP_POP_MIDDLE
				|| op == fmbq_pkg::OP_POP_BACK) begin
			if (depth == 0) begin
				r.popped = -1;
				r.empty = 1'b1;
			end else if (op == fmbq_pkg::OP_POP_FRONT) begin
				r.popped = shadow_words.pop_front();
			end else if (op == fmbq_pkg::OP_POP_MIDDLE) begin
				idx = (depth - 1) / 2;
				r.popped = shadow_words[idx];
				shadow_words.delete(idx);
			end else begin
				r.popped = shadow_words.pop_back();
			end
		end
		r.count = fmbq_pkg::CNT_W'(shadow_words.size());
		return r;
	endfunction

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [fmbq_pkg::OP_W-1:0] push_op();
		case ($urandom_range(0, 2))
			0: return fmbq_pkg::OP_PUSH_FRONT;
			1: return fmbq_pkg::OP_PUSH_MIDDLE;
			default: return fmbq_pkg::OP_PUSH_BACK;
		endcase
	endfunction

	function automatic logic [fmbq_pkg::OP_W-1:0] pop_op();
		case ($urandom_range(0, 2))
			0: return fmbq_pkg::OP_POP_FRONT;
			1: return fmbq_pkg::OP_POP_MIDDLE;
			default: return fmbq_pkg::OP_POP_BACK;
		endcase
	endfunction

	function automatic logic [fmbq_pkg::OP_W-1:0] pick_op(input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
		if (r < 2 + push_pct)
			return push_op();
		return pop_op();
	endfunction

	function automatic logic signed [fmbq_pkg::WORD_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return -1;
			3: return 0;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_row(input logic [fmbq_pkg::OP_W-1:0] op,
			input logic signed [fmbq_pkg::WORD_W-1:0] val,
			input bit typed, input logic signed [fmbq_pkg::WORD_W-1:0] popped = 0,
			input logic empty = 1'b0, input logic full = 1'b0,
			input logic [fmbq_pkg::CNT_W-1:0] count = '0);
		script_row_t row;
		row.op = op;
		row.val = val;
		row.typed = typed;
		row.want = '{popped: popped, empty: empty, full: full, count: count};
		script.push_back(row);
	endtask

	// Offers one transaction, records what it should produce, then maybe idles.
	task automatic transact(input logic [fmbq_pkg::OP_W-1:0] op,
			input logic signed [fmbq_pkg::WORD_W-1:0] val,
			input bit typed, input qresult_t want);
		qresult_t predicted;
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		push_value <= val;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = queue_step(op, val);
		awaited_results.push_back(typed ? want : predicted);
		if (send_quiet > 0) begin
			send_quiet--;
			gap = 0;
		end else if ($urandom_range(0, 99) < 4) begin
			send_quiet = $urandom_range(20, 60);
			gap = 0;
		end else begin
			gap = draw_gap();
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic random_mix(input int n, input int push_pct);
		repeat (n) transact(pick_op(push_pct), random_word(), 1'b0, '0);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = fmbq_pkg::OP_PUSH_FRONT;
		push_value = '0;

		// Empty pops, spare codes and the value extremes have results known up front.
		add_row(fmbq_pkg::OP_POP_FRONT, 0, 1'b1, -1, 1'b1, 1'b0, 0);
		add_row(fmbq_pkg::OP_POP_MIDDLE, 32'sh7FFFFFFF, 1'b1, -1, 1'b1, 1'b0, 0);
		add_row(fmbq_pkg::OP_POP_BACK, 0, 1'b1, -1, 1'b1, 1'b0, 0);
		add_row(OP_SPARE_6, 0, 1'b1, 0, 1'b0, 1'b0, 0);
		add_row(OP_SPARE_7, 32'sh80000000, 1'b1, 0, 1'b0, 1'b0, 0);
		add_row(fmbq_pkg::OP_PUSH_BACK, 32'sh7FFFFFFF, 1'b1, 0, 1'b0, 1'b0, 1);
		add_row(fmbq_pkg::OP_PUSH_FRONT, 32'sh80000000, 1'b1, 0, 1'b0, 1'b0, 2);
		add_row(fmbq_pkg::OP_PUSH_MIDDLE, 0, 1'b1, 0, 1'b0, 1'b0, 3);
		add_row(fmbq_pkg::OP_PUSH_MIDDLE, -1, 1'b1, 0, 1'b0, 1'b0, 4);
		add_row(fmbq_pkg::OP_PUSH_BACK, 32'sh55555555, 1'b1, 0, 1'b0, 1'b0, 5);
		add_row(fmbq_pkg::OP_PUSH_FRONT, 32'shAAAAAAAA, 1'b1, 0, 1'b0, 1'b0, 6);
		add_row(OP_SPARE_6, -1, 1'b1, 0, 1'b0, 1'b0, 6);
		add_row(fmbq_pkg::OP_POP_MIDDLE, 0, 1'b0);
		add_row(fmbq_pkg::OP_POP_MIDDLE, 0, 1'b0);
		add_row(fmbq_pkg::OP_POP_FRONT, 0, 1'b0);
		add_row(fmbq_pkg::OP_POP_BACK, 0, 1'b0);
		add_row(fmbq_pkg::OP_POP_MIDDLE, 0, 1'b0);
		add_row(fmbq_pkg::OP_POP_BACK, 0, 1'b0);
		add_row(fmbq_pkg::OP_POP_MIDDLE, 0, 1'b1, -1, 1'b1, 1'b0, 0);
		add_row(fmbq_pkg::OP_PUSH_MIDDLE, 32'sh12345678, 1'b0);
		add_row(fmbq_pkg::OP_PUSH_MIDDLE, 32'sh0F0F0F0F, 1'b0);
		add_row(fmbq_pkg::OP_POP_MIDDLE, 0, 1'b0);
		add_row(fmbq_pkg::OP_POP_BACK, 0, 1'b0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			transact(script[i].op, script[i].val, script[i].typed, script[i].want);

		random_mix(310, 50);
		drain_results();

		random_mix(310, 55);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_front_middle_back_queue_top: clean");
		else
			$display("tb_front_middle_back_queue_top: errors");
		$finish;
	end

	// Result side: random stalls, quiet stretches, and one long hold-off that backs up the block.
	initial begin
		int stall_left;
		int quiet_left;
		bit hold_done;
		stall_left = 0;
		quiet_left = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (quiet_left > 0) begin
				quiet_left--;
				out_ready <= 1'b1;
			end else begin
				if ($urandom_range(0, 99) < 5)
					quiet_left = $urandom_range(30, 80);
				else
					stall_left = draw_gap();
				out_ready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		qresult_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transaction: popped_value %0d entry_count %0d",
					$time, popped_value, entry_count);
			end else begin
				want = awaited_results.pop_front();
				if (popped_value !== want.popped) begin
					mismatches++;
					$display("%0t: popped_value expected %0d actual %0d",
						$time, want.popped, popped_value);
				end
				if (was_empty !== want.empty) begin
					mismatches++;
					$display("%0t: was_empty expected %0b actual %0b",
						$time, want.empty, was_empty);
				end
				if (was_full !== want.full) begin
					mismatches++;
					$display("%0t: was_full expected %0b actual %0b",
						$time, want.full, was_full);
				end
				if (entry_count !== want.count) begin
					mismatches++;
					$display("%0t: entry_count expected %0d actual %0d",
						$time, want.count, entry_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_front_middle_back_queue_top: errors");
			$finish;
		end
	end

endmodule
